[rtl/core/sha1_stream_hash_defines.svh]
`ifndef SHA1_STREAM_HASH_DEFINES_SVH
`define SHA1_STREAM_HASH_DEFINES_SVH

// Concurrent check that is switched off while the reset is asserted.
`define SHA1SH_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sha1 stream hash check failed");

// Concurrent check that also holds while the reset is asserted.
`define SHA1SH_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sha1 stream hash check failed");

`endif

[rtl/core/sha1sh_pkg.sv]
package sha1sh_pkg;

  localparam int unsigned NUM_ROUNDS   = 80;
  localparam int unsigned BLOCK_BYTES  = 64;
  localparam int unsigned LEN_POS      = 56;
  localparam int unsigned DIGEST_WORDS = 5;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [2:0] LAST_IDX = 3'(DIGEST_WORDS - 1);

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Element 0 is h0.
  typedef logic [DIGEST_WORDS-1:0][31:0] chain_t;

  localparam chain_t IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                           32'hEFCDAB89, 32'h67452301};

  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       round_en;
    logic [6:0] round_idx;
    logic       accum;
    logic       load_iv;
  } eng_ctrl_t;

endpackage

[rtl/core/sha1sh_engine.sv]
module sha1sh_engine
  import sha1sh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  eng_ctrl_t ctrl_i,
  output chain_t    chain_o
);

  // The block buffer and the rolling schedule share one 512-bit shift line.
  // Bytes enter at the bottom, so the first byte of a block ends up in the
  // top byte; each round consumes the top word and appends the next one.
  logic [511:0] sched_q, sched_d;
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  chain_t       chain_q, chain_d;

  logic [31:0] w0, w2, w8, w13, w_next;
  logic [31:0] ra, rb, rc, rd, re;
  logic [31:0] f, k, t;

  assign w0  = sched_q[511:480];
  assign w2  = sched_q[447:416];
  assign w8  = sched_q[255:224];
  assign w13 = sched_q[95:64];

  always_comb begin
    logic [31:0] x;
    x      = w13 ^ w8 ^ w2 ^ w0;
    w_next = {x[30:0], x[31]};
  end

  // The first round starts from the chaining words directly.
  always_comb begin
    if (ctrl_i.round_idx == 7'd0) begin
      ra = chain_q[0];
      rb = chain_q[1];
      rc = chain_q[2];
      rd = chain_q[3];
      re = chain_q[4];
    end else begin
      ra = a_q;
      rb = b_q;
      rc = c_q;
      rd = d_q;
      re = e_q;
    end
  end

  always_comb begin
    priority if (ctrl_i.round_idx < 7'd20) begin
      f = (rb & rc) | (~rb & rd);
      k = K0;
    end else if (ctrl_i.round_idx < 7'd40) begin
      f = rb ^ rc ^ rd;
      k = K1;
    end else if (ctrl_i.round_idx < 7'd60) begin
      f = (rb & rc) | (rb & rd) | (rc & rd);
      k = K2;
    end else begin
      f = rb ^ rc ^ rd;
      k = K3;
    end
    t = {ra[26:0], ra[31:27]} + f + re + k + w0;
  end

  always_comb begin
    priority if (ctrl_i.push) begin
      sched_d = {sched_q[503:0], ctrl_i.push_byte};
    end else if (ctrl_i.round_en) begin
      sched_d = {sched_q[479:0], w_next};
    end else begin
      sched_d = sched_q;
    end
  end

  always_comb begin
    chain_d = chain_q;
    priority if (ctrl_i.load_iv) begin
      chain_d = IV;
    end else if (ctrl_i.accum) begin
      chain_d[0] = chain_q[0] + a_q;
      chain_d[1] = chain_q[1] + b_q;
      chain_d[2] = chain_q[2] + c_q;
      chain_d[3] = chain_q[3] + d_q;
      chain_d[4] = chain_q[4] + e_q;
    end else begin
      chain_d = chain_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sched_q <= sched_d;
    if (ctrl_i.round_en) begin
      a_q <= t;
      b_q <= ra;
      c_q <= {rb[1:0], rb[31:2]};
      d_q <= rc;
      e_q <= rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= IV;
    end else begin
      chain_q <= chain_d;
    end
  end

  assign chain_o = chain_q;

endmodule

[rtl/core/sha1_stream_hash.sv]
// An append item is taken while idle; the 64th byte of a block stalls the input for
// the 80 rounds of the shared round adder and the fold into h0..h4.
// A finish item pushes one pad byte per cycle up to the block end, compresses one
// or two blocks, then presents the five digest words one per cycle unless stalled.
// Reset is asynchronous and active low: chaining words return to the initial
// hash values, byte and fill counters to zero; the block buffer is not cleared.
module sha1_stream_hash
  import sha1sh_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_ACCUM = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  localparam logic [5:0] LAST_FILL  = 6'(BLOCK_BYTES - 1);
  localparam logic [5:0] LEN_START  = 6'(LEN_POS);
  localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] msg_q, msg_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic        fin_q, fin_d;
  logic        first_q, first_d;
  logic        long_q, long_d;
  logic        final_q, final_d;

  eng_ctrl_t   ctrl;
  chain_t      chain;
  logic [63:0] bit_len;
  logic [2:0]  len_sel;
  logic [7:0]  pad_byte;

  assign bit_len = {msg_q, 3'b000};
  assign len_sel = 3'(3'd7 - fill_q[2:0]);

  // The mark byte comes first; the length fills the last eight bytes of the
  // final block only, so a two-block tail pads its first block with zeros.
  always_comb begin
    priority if (first_q) begin
      pad_byte = PAD_MARK;
    end else if (!long_q && (fill_q >= LEN_START)) begin
      pad_byte = bit_len[{len_sel, 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    msg_d   = msg_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    fin_d   = fin_q;
    first_d = first_q;
    long_d  = long_q;
    final_d = final_q;
    ctrl    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.command == CMD_APPEND) begin
            ctrl.push      = 1'b1;
            ctrl.push_byte = in_item_i.data_byte;
            msg_d          = msg_q + 61'd1;
            fill_d         = fill_q + 6'd1;
            if (fill_q == LAST_FILL) begin
              final_d = 1'b0;
              rnd_d   = '0;
              state_d = ST_ROUND;
            end
          end else begin
            fin_d   = 1'b1;
            first_d = 1'b1;
            long_d  = (fill_q >= LEN_START);
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        ctrl.push      = 1'b1;
        ctrl.push_byte = pad_byte;
        first_d        = 1'b0;
        fill_d         = fill_q + 6'd1;
        if (fill_q == LAST_FILL) begin
          final_d = !long_q;
          long_d  = 1'b0;
          rnd_d   = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        ctrl.round_en  = 1'b1;
        ctrl.round_idx = rnd_q;
        rnd_d          = rnd_q + 7'd1;
        if (rnd_q == LAST_ROUND) begin
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        ctrl.accum = 1'b1;
        priority if (final_q) begin
          idx_d   = '0;
          state_d = ST_EMIT;
        end else if (fin_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == LAST_IDX) begin
            ctrl.load_iv = 1'b1;
            msg_d        = '0;
            fin_d        = 1'b0;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      msg_q   <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      fin_q   <= 1'b0;
      first_q <= 1'b0;
      long_q  <= 1'b0;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      msg_q   <= msg_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      fin_q   <= fin_d;
      first_q <= first_d;
      long_q  <= long_d;
      final_q <= final_d;
    end
  end

  sha1sh_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .chain_o (chain)
  );

  assign in_stall_o             = (state_q != ST_IDLE);
  assign out_valid_o            = (state_q == ST_EMIT);
  assign out_item_o.digest_word = chain[idx_q];
  assign out_item_o.word_index  = idx_q;
  assign out_item_o.last_word   = (idx_q == LAST_IDX);

endmodule

[rtl/core/sha1sh_checker.sv]
`include "sha1_stream_hash_defines.svh"

module sha1sh_checker
  import sha1sh_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A stalled digest word stays on the port unchanged.
  `SHA1SH_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))

  // No item is taken while the digest is being delivered.
  `SHA1SH_ASSERT_ALWAYS(a_no_in_during_out, clk_i, out_valid_o |-> in_stall_o)

  // The last-word flag marks exactly the fifth word.
  `SHA1SH_ASSERT(a_last_flag, clk_i, rst_ni, out_valid_o |-> (out_item_o.last_word == (out_item_o.word_index == LAST_IDX)) && (out_item_o.word_index <= LAST_IDX))

  // Nothing follows the fifth word.
  `SHA1SH_ASSERT(a_end_of_digest, clk_i, rst_ni, out_valid_o && !out_stall_i && out_item_o.last_word |=> !out_valid_o)

  // A finish item always starts padding, so the input side stalls next.
  `SHA1SH_ASSERT(a_finish_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && (in_item_i.command == CMD_FINISH) |=> in_stall_o && !out_valid_o)

endmodule

bind sha1_stream_hash sha1sh_checker u_checker (.*);
